>>> sv/bmpc_pkg.sv
// Shared types, constants and color packing functions for the BMP pixel converter.
// Depends on nothing; bmpc_gather, bmpc_convert and the top level import it.
package bmpc_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
    localparam int POS_W      = $clog2(MAX_DIM) + 2;   // byte position within a row
    localparam int PITCH_W    = POS_W + 1;             // holds the pitch itself
    localparam int COORD_W    = 10;
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);
    localparam int COLOR_W    = 24;
    localparam int PIXEL_W    = 16;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 40;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_BPP    = 2'd0;
    localparam logic [1:0] REG_WIDE   = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [2:0]       BPP_RESET    = 3'd3;
    localparam logic [DIM_W-1:0] DIM_RESET    = DIM_W'(1);
    localparam logic [DIM_W-1:0] DIM_MAX      = DIM_W'(MAX_DIM);

    // Input word kinds (s_tuser)
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // Effective source formats
    localparam logic [2:0] BPP_PALETTE = 3'd1;
    localparam logic [2:0] BPP_RGB565  = 3'd2;
    localparam logic [2:0] BPP_BGRX    = 3'd4;

    typedef struct packed {
        logic [2:0]         bpp;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [PITCH_W-1:0] active;
        logic [PITCH_W-1:0] pitch;
    } bmpc_cfg_t;

    // Word handed from the gather stage to the convert stage
    typedef struct packed {
        logic               valid;
        logic               pal;
        logic               rgb565_in;
        logic [COLOR_W-1:0] gather;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last;
    } bmpc_item_t;

    function automatic logic [PIXEL_W-1:0] bgr_to_332(input logic [COLOR_W-1:0] c);
        return {8'h00, c[23:21], c[15:13], c[7:6]};
    endfunction

    function automatic logic [PIXEL_W-1:0] bgr_to_565(input logic [COLOR_W-1:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic logic [PIXEL_W-1:0] rgb565_to_332(input logic [PIXEL_W-1:0] c);
        return {8'h00, c[15:13], c[10:8], c[4:3]};
    endfunction

endpackage

>>> sv/bmpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds its read data while rd_en is low.
module bmpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/bmpc_gather.sv
// Gather stage: row/pixel position tracking, little-endian byte gather, padding skip.
// Depends on bmpc_pkg; feeds one registered bmpc_item_t to the convert stage.
module bmpc_gather import bmpc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       restart,
    input  bmpc_cfg_t  cfg,
    input  logic       data_acc,      // pixel-array word accepted this cycle
    input  logic [7:0] data_byte,
    input  logic       adv,           // convert stage takes the held item
    output bmpc_item_t item
);

    logic [COLOR_W-1:0] gather_reg, gather_next;
    logic [1:0]         bip_reg, bip_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] frow_reg, frow_next;
    bmpc_item_t         item_reg, item_next;

    logic [COLOR_W-1:0] merged;
    logic [2:0]         bip_inc;
    logic [PITCH_W-1:0] pos_inc;
    logic [DIM_W-1:0]   fr;
    logic [DIM_W-1:0]   frow_inc;
    logic               in_active;
    logic               emit;
    logic               ld;

    always_comb begin
        case (bip_reg)
            2'd0:    merged = gather_reg | {16'h0000, data_byte};
            2'd1:    merged = gather_reg | {8'h00, data_byte, 8'h00};
            2'd2:    merged = gather_reg | {data_byte, 16'h0000};
            default: merged = gather_reg;   // fourth byte of BGRX: drop
        endcase
    end

    assign bip_inc   = {1'b0, bip_reg} + 3'd1;
    assign pos_inc   = {1'b0, pos_reg} + PITCH_W'(1);
    assign in_active = {1'b0, pos_reg} < cfg.active;
    assign emit      = in_active && (bip_inc >= cfg.bpp);
    assign fr        = ({1'b0, frow_reg} < cfg.height) ? {1'b0, frow_reg}
                                                       : cfg.height - DIM_W'(1);
    assign frow_inc  = {1'b0, frow_reg} + DIM_W'(1);
    assign ld        = !item_reg.valid || adv;

    always_comb begin
        gather_next = gather_reg;
        bip_next    = bip_reg;
        pos_next    = pos_reg;
        col_next    = col_reg;
        frow_next   = frow_reg;
        if (restart) begin
            gather_next = '0;
            bip_next    = '0;
            pos_next    = '0;
            col_next    = '0;
            frow_next   = '0;
        end else if (data_acc) begin
            if (in_active) begin
                if (emit) begin
                    col_next    = col_reg + COORD_W'(1);
                    bip_next    = '0;
                    gather_next = '0;
                end else begin
                    bip_next    = bip_inc[1:0];
                    gather_next = merged;
                end
            end
            if (pos_inc >= cfg.pitch) begin
                pos_next    = '0;
                col_next    = '0;
                bip_next    = '0;
                gather_next = '0;
                frow_next   = (frow_inc >= cfg.height) ? '0 : frow_inc[COORD_W-1:0];
            end else begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    always_comb begin
        item_next = item_reg;
        if (ld) begin
            item_next.valid = data_acc && emit;
        end
        if (data_acc && emit) begin
            item_next.pal       = (cfg.bpp == BPP_PALETTE);
            item_next.rgb565_in = (cfg.bpp == BPP_RGB565);
            item_next.gather    = merged;
            item_next.column    = col_reg;
            item_next.row       = COORD_W'(cfg.height - DIM_W'(1) - fr);
            item_next.last      = (fr == cfg.height - DIM_W'(1))
                               && ({1'b0, col_reg} == cfg.width - DIM_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gather_reg     <= '0;
            bip_reg        <= '0;
            pos_reg        <= '0;
            col_reg        <= '0;
            frow_reg       <= '0;
            item_reg.valid <= 1'b0;
        end else begin
            gather_reg     <= gather_next;
            bip_reg        <= bip_next;
            pos_reg        <= pos_next;
            col_reg        <= col_next;
            frow_reg       <= frow_next;
            item_reg.valid <= item_next.valid;
        end
        // payload needs no reset: it is only looked at while valid is set
        item_reg.pal       <= item_next.pal;
        item_reg.rgb565_in <= item_next.rgb565_in;
        item_reg.gather    <= item_next.gather;
        item_reg.column    <= item_next.column;
        item_reg.row       <= item_next.row;
        item_reg.last      <= item_next.last;
    end

    assign item = item_reg;

endmodule

>>> sv/bmpc_convert.sv
// Convert stage: palette/raw color select, RGB332 or RGB565 packing, output register.
// Depends on bmpc_pkg; takes the gather stage item and the palette read data.
module bmpc_convert import bmpc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  bmpc_item_t          item,
    input  logic [COLOR_W-1:0]  pal_color,
    input  logic                wide,
    output logic                adv,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg, data_next;
    logic                last_reg;
    logic [COLOR_W-1:0]  color;
    logic [PIXEL_W-1:0]  pixel;

    assign adv   = !valid_reg || m_tready;
    assign color = item.pal ? pal_color : item.gather;

    always_comb begin
        if (item.rgb565_in) begin
            pixel = wide ? item.gather[PIXEL_W-1:0] : rgb565_to_332(item.gather[PIXEL_W-1:0]);
        end else begin
            pixel = wide ? bgr_to_565(color) : bgr_to_332(color);
        end
        data_next = {4'h0, item.row, item.column, pixel};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && item.valid) begin
            data_reg <= data_next;
            last_reg <= item.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

>>> sv/bmp_pixel_stream_to_rgb332_rgb565.sv
// BMP pixel-array stream to RGB332/RGB565 converter, top level; uses bmpc_pkg,
// bmpc_ram, bmpc_gather and bmpc_convert.
// A pixel-completing word passes the gather register, then the output register, to m_tvalid.
// Throughput: one input word per cycle unless m_tready low stalls the pipe, set by the two-register
// gather/convert pipe and the registered palette read; padding and palette words give no output word.
// Reset (aresetn low, synchronous): registers to 3 bytes/pixel, narrow output, 1x1
// image, stream position cleared, pipe emptied; palette contents are not cleared.
module bmp_pixel_stream_to_rgb332_rgb565 import bmpc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // palette_index[7:0], palette_color[31:8],
                                           // data_byte[39:32]
    input  logic                s_tuser,   // op: 0 palette write, 1 pixel-array byte
    // Output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // pixel[15:0], column[25:16], row[35:26],
                                           // zero[39:36]
    output logic                m_tlast,   // last pixel of the image
    // Register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic [2:0]       bpp_reg;
    logic             wide_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    logic             cfg_wr;
    bmpc_cfg_t        cfg;
    bmpc_item_t       item;
    logic             adv;
    logic             s_acc;
    logic             data_acc;
    logic             pal_wr;
    logic             pal_rd;
    logic [COLOR_W-1:0] pal_color;

    // ------------------------------------------------------------------
    // Register port: zero-wait writes, any write restarts the image stream
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg    <= BPP_RESET;
            wide_reg   <= 1'b0;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BPP:    bpp_reg    <= pwdata[2:0];
                REG_WIDE:   wide_reg   <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BPP:    prdata = APB_DW'(bpp_reg);
            REG_WIDE:   prdata = APB_DW'(wide_reg);
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective geometry: clamp out-of-range settings, derive row pitch. The user must
    // change the registers only while idle, which the block does not enforce; so this stays off the data path timing.
    // ------------------------------------------------------------------
    always_comb begin
        case (bpp_reg)
            3'd0:         cfg.bpp = BPP_PALETTE;
            3'd1, 3'd2,
            3'd3, 3'd4:   cfg.bpp = bpp_reg;
            default:      cfg.bpp = BPP_BGRX;
        endcase
        cfg.width  = (width_reg == '0)  ? DIM_W'(1)
                   : (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
        cfg.height = (height_reg == '0) ? DIM_W'(1)
                   : (height_reg > DIM_MAX) ? DIM_MAX : height_reg;
        // bytes of pixel data per row, then round up to a 4-byte pitch
        cfg.active = PITCH_W'({2'b00, cfg.width} * {10'd0, cfg.bpp});
        cfg.pitch  = (cfg.active + PITCH_W'(3)) & ~PITCH_W'(3);
    end

    // ------------------------------------------------------------------
    // Input handshake: take a word whenever the gather register is free or moves on
    // ------------------------------------------------------------------
    assign s_tready = !item.valid || adv;
    assign s_acc    = s_tvalid && s_tready;
    assign data_acc = s_acc && (s_tuser == OP_PIXEL);
    assign pal_wr   = s_acc && (s_tuser == OP_PALETTE);
    // Look up on every palette-mode byte; the read data lines up with the gather register
    assign pal_rd   = data_acc && (cfg.bpp == BPP_PALETTE);

    bmpc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr),
        .wr_addr (s_tdata[PAL_AW-1:0]),
        .wr_data (s_tdata[31:8]),
        .rd_en   (pal_rd),
        .rd_addr (s_tdata[39:32]),
        .rd_data (pal_color)
    );

    bmpc_gather u_gather (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (cfg_wr),
        .cfg       (cfg),
        .data_acc  (data_acc),
        .data_byte (s_tdata[39:32]),
        .adv       (adv),
        .item      (item)
    );

    bmpc_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .pal_color (pal_color),
        .wide      (wide_reg),
        .adv       (adv),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // An empty output register always leaves room for a new input word
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // The last pixel always belongs to the top output row
    a_last_top_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[35:26] == '0))
        else $error("last pixel not on row zero");

    // A palette write never produces a pixel in the gather register
    a_pal_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_PALETTE)) |=> !item.valid)
        else $error("palette write produced a pixel");

    // A narrow pixel keeps its upper byte clear
    a_narrow_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !wide_reg) |-> (m_tdata[15:8] == '0))
        else $error("RGB332 pixel with nonzero upper byte");

endmodule
